[rtl/bioreg_pkg.sv]
// shared constants and types for the board i/o register decoder
package bioreg_pkg;

  // field widths
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int SND_REG_W  = 5;
  localparam int SPR_FIELD_W = 4;
  localparam int CFG_IDX_W  = 2;

  // sprite position store
  localparam int SPRITE_STORE_DEPTH = 16;

  // write addresses (exact decode)
  localparam logic [ADDR_W-1:0] ADDR_IRQ_EN    = 16'h5000;
  localparam logic [ADDR_W-1:0] ADDR_FLIP      = 16'h5003;
  localparam logic [ADDR_W-1:0] ADDR_PALETTE   = 16'h5070;
  localparam logic [ADDR_W-1:0] ADDR_COLOR_TBL = 16'h5071;
  localparam logic [ADDR_W-1:0] ADDR_PRIORITY  = 16'h5073;
  localparam logic [ADDR_W-1:0] ADDR_CHAR_BANK = 16'h5074;
  localparam logic [ADDR_W-1:0] ADDR_SPR_BANK  = 16'h5075;
  localparam logic [ADDR_W-1:0] ADDR_SCROLL    = 16'h5080;

  // windows: sound 0x5040..0x505f, sprite store 0x5060..0x506f
  localparam logic [10:0] SOUND_WIN  = 11'h282;
  localparam logic [11:0] SPRITE_WIN = 12'h506;

  // read decode: page 0x50xx mirrored in 64-byte steps
  localparam logic [7:0]        IO_PAGE      = 8'h50;
  localparam logic [ADDR_W-1:0] MIRROR_MASK  = 16'hffc0;
  localparam logic [ADDR_W-1:0] ADDR_RD_P1   = 16'h5000;
  localparam logic [ADDR_W-1:0] ADDR_RD_P2   = 16'h5040;
  localparam logic [ADDR_W-1:0] ADDR_RD_DIPC = 16'h5080;

  // merge masks for the input ports and dip bits
  localparam logic [DATA_W-1:0] P1_MASK   = 8'hef;
  localparam logic [DATA_W-1:0] DIPA_MASK = 8'h10;
  localparam logic [DATA_W-1:0] P2_MASK   = 8'h6f;
  localparam logic [DATA_W-1:0] DIPB_MASK = 8'h90;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIP_C = 2'd2;
  localparam logic [DATA_W-1:0] DIP_A_RESET = 8'h10;
  localparam logic [DATA_W-1:0] DIP_B_RESET = 8'h90;
  localparam logic [DATA_W-1:0] DIP_C_RESET = 8'h69;

  // request type
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // decode of one bus access
  typedef struct packed {
    logic                   wr_irq;
    logic                   wr_flip;
    logic                   wr_palette;
    logic                   wr_color;
    logic                   wr_priority;
    logic                   wr_char;
    logic                   wr_spr_bank;
    logic                   wr_scroll;
    logic                   wr_sprite;
    logic [SPR_FIELD_W-1:0] sprite_idx;
    logic                   sound_strobe;
    logic [SND_REG_W-1:0]   sound_register;
    logic [DATA_W-1:0]      read_data;
  } decode_t;

endpackage

[rtl/bioreg_decode.sv]
// address decode of one bus access: latch write enables, sound strobe, read mux
module bioreg_decode (
  input  logic                                 req_type,
  input  logic [bioreg_pkg::ADDR_W-1:0]        bus_address,
  input  logic [bioreg_pkg::DATA_W-1:0]        player_one_port,
  input  logic [bioreg_pkg::DATA_W-1:0]        player_two_port,
  input  logic [bioreg_pkg::DATA_W-1:0]        dip_bank_a,
  input  logic [bioreg_pkg::DATA_W-1:0]        dip_bank_b,
  input  logic [bioreg_pkg::DATA_W-1:0]        dip_bank_c,
  output bioreg_pkg::decode_t                  dec
);

  logic                          is_write;
  logic [bioreg_pkg::ADDR_W-1:0] rd_addr;

  assign is_write = (req_type == bioreg_pkg::REQ_WRITE);

  // mirror reads inside the i/o page
  assign rd_addr = (bus_address[15:8] == bioreg_pkg::IO_PAGE) ?
                   (bus_address & bioreg_pkg::MIRROR_MASK) : bus_address;

  always_comb begin
    dec = '0;
    dec.sprite_idx = bus_address[bioreg_pkg::SPR_FIELD_W-1:0];

    // write decode, exact addresses first, then the windows
    if (is_write) begin
      case (bus_address)
        bioreg_pkg::ADDR_IRQ_EN:    dec.wr_irq      = 1'b1;
        bioreg_pkg::ADDR_FLIP:      dec.wr_flip     = 1'b1;
        bioreg_pkg::ADDR_PALETTE:   dec.wr_palette  = 1'b1;
        bioreg_pkg::ADDR_COLOR_TBL: dec.wr_color    = 1'b1;
        bioreg_pkg::ADDR_PRIORITY:  dec.wr_priority = 1'b1;
        bioreg_pkg::ADDR_CHAR_BANK: dec.wr_char     = 1'b1;
        bioreg_pkg::ADDR_SPR_BANK:  dec.wr_spr_bank = 1'b1;
        bioreg_pkg::ADDR_SCROLL:    dec.wr_scroll   = 1'b1;
        default: begin
          if (bus_address[15:5] == bioreg_pkg::SOUND_WIN) begin
            dec.sound_strobe   = 1'b1;
            dec.sound_register = bus_address[bioreg_pkg::SND_REG_W-1:0];
          end else if (bus_address[15:4] == bioreg_pkg::SPRITE_WIN) begin
            dec.wr_sprite = 1'b1;
          end
        end
      endcase
    end else begin
      // read mux: player ports merged with dip bits
      case (rd_addr)
        bioreg_pkg::ADDR_RD_P1:
          dec.read_data = (player_one_port & bioreg_pkg::P1_MASK) |
                          (dip_bank_a & bioreg_pkg::DIPA_MASK);
        bioreg_pkg::ADDR_RD_P2:
          dec.read_data = (player_two_port & bioreg_pkg::P2_MASK) |
                          (dip_bank_b & bioreg_pkg::DIPB_MASK);
        bioreg_pkg::ADDR_RD_DIPC:
          dec.read_data = dip_bank_c;
        default:
          dec.read_data = '0;
      endcase
    end
  end

endmodule

[rtl/board_io_register_decode.sv]
// top level: input register, decode, latches, sprite store and result register
// an accepted request word passes the input register, then the result register;
//   decode and latch update sit between the two
// throughput: one word per cycle; rsp_stall holds the result and backs up req_stall
// reset: rst synchronous active high; clears latches, sprite store, valids and
//   restores dip banks to 0x10 / 0x90 / 0x69
module board_io_register_decode #(
  parameter int SPRITE_STORE_DEPTH = bioreg_pkg::SPRITE_STORE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic                               req_type,
  input  logic [bioreg_pkg::ADDR_W-1:0]      bus_address,
  input  logic [bioreg_pkg::DATA_W-1:0]      write_data,
  input  logic [bioreg_pkg::DATA_W-1:0]      player_one_port,
  input  logic [bioreg_pkg::DATA_W-1:0]      player_two_port,
  input  logic [bioreg_pkg::SPR_FIELD_W-1:0] sprite_read_index,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bioreg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bioreg_pkg::DATA_W-1:0]      cfg_data,
  // result channel
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic [bioreg_pkg::DATA_W-1:0]      read_data,
  output logic                               sound_strobe,
  output logic [bioreg_pkg::SND_REG_W-1:0]   sound_register,
  output logic [bioreg_pkg::DATA_W-1:0]      irq_enable,
  output logic                               flip_screen,
  output logic [bioreg_pkg::DATA_W-1:0]      palette_bank,
  output logic [bioreg_pkg::DATA_W-1:0]      color_table_bank,
  output logic                               background_priority,
  output logic                               character_bank,
  output logic                               sprite_bank,
  output logic [bioreg_pkg::DATA_W-1:0]      scroll_y,
  output logic [bioreg_pkg::DATA_W-1:0]      sprite_read_value
);

  localparam int IDX_W = $clog2(SPRITE_STORE_DEPTH);

  // configuration
  logic [bioreg_pkg::DATA_W-1:0] dip_bank_a;
  logic [bioreg_pkg::DATA_W-1:0] dip_bank_b;
  logic [bioreg_pkg::DATA_W-1:0] dip_bank_c;

  // input register
  logic                               s1_valid;
  logic                               s1_type;
  logic [bioreg_pkg::ADDR_W-1:0]      s1_addr;
  logic [bioreg_pkg::DATA_W-1:0]      s1_data;
  logic [bioreg_pkg::DATA_W-1:0]      s1_p1;
  logic [bioreg_pkg::DATA_W-1:0]      s1_p2;
  logic [bioreg_pkg::SPR_FIELD_W-1:0] s1_ridx;

  // latches and sprite store
  logic [bioreg_pkg::DATA_W-1:0] irq_latch;
  logic                          flip_latch;
  logic [bioreg_pkg::DATA_W-1:0] palette_latch;
  logic [bioreg_pkg::DATA_W-1:0] color_latch;
  logic                          priority_latch;
  logic                          char_latch;
  logic                          spr_bank_latch;
  logic [bioreg_pkg::DATA_W-1:0] scroll_latch;
  logic [bioreg_pkg::DATA_W-1:0] sprite_store [SPRITE_STORE_DEPTH];

  bioreg_pkg::decode_t           dec;
  logic                          advance;
  logic                          s1_load;
  logic                          fire;
  logic [IDX_W-1:0]              wr_idx;
  logic [IDX_W-1:0]              rd_idx;
  logic [bioreg_pkg::DATA_W-1:0] sprite_value_next;

  // handshake
  assign advance   = !rsp_valid || !rsp_stall;
  assign s1_load   = !s1_valid || advance;
  assign req_stall = !s1_load;
  assign fire      = s1_valid && advance;
  assign cfg_ready = 1'b1;

  // dip bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dip_bank_a <= bioreg_pkg::DIP_A_RESET;
      dip_bank_b <= bioreg_pkg::DIP_B_RESET;
      dip_bank_c <= bioreg_pkg::DIP_C_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bioreg_pkg::CFG_DIP_A: dip_bank_a <= cfg_data;
        bioreg_pkg::CFG_DIP_B: dip_bank_b <= cfg_data;
        bioreg_pkg::CFG_DIP_C: dip_bank_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= req_valid;
    end
    if (s1_load && req_valid) begin
      s1_type <= req_type;
      s1_addr <= bus_address;
      s1_data <= write_data;
      s1_p1   <= player_one_port;
      s1_p2   <= player_two_port;
      s1_ridx <= sprite_read_index;
    end
  end

  bioreg_decode u_decode (
    .req_type        (s1_type),
    .bus_address     (s1_addr),
    .player_one_port (s1_p1),
    .player_two_port (s1_p2),
    .dip_bank_a      (dip_bank_a),
    .dip_bank_b      (dip_bank_b),
    .dip_bank_c      (dip_bank_c),
    .dec             (dec)
  );

  // sprite store read with forwarding of this word's write
  assign wr_idx = dec.sprite_idx[IDX_W-1:0];
  assign rd_idx = s1_ridx[IDX_W-1:0];
  assign sprite_value_next = (dec.wr_sprite && (wr_idx == rd_idx)) ?
                             s1_data : sprite_store[rd_idx];

  // control latches and sprite store
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_latch      <= '0;
      flip_latch     <= 1'b0;
      palette_latch  <= '0;
      color_latch    <= '0;
      priority_latch <= 1'b0;
      char_latch     <= 1'b0;
      spr_bank_latch <= 1'b0;
      scroll_latch   <= '0;
      for (int i = 0; i < SPRITE_STORE_DEPTH; i++) begin
        sprite_store[i] <= '0;
      end
    end else if (fire) begin
      if (dec.wr_irq)      irq_latch      <= s1_data;
      if (dec.wr_flip)     flip_latch     <= s1_data[0];
      if (dec.wr_palette)  palette_latch  <= s1_data;
      if (dec.wr_color)    color_latch    <= s1_data;
      if (dec.wr_priority) priority_latch <= s1_data[0];
      if (dec.wr_char)     char_latch     <= s1_data[0];
      if (dec.wr_spr_bank) spr_bank_latch <= s1_data[0];
      if (dec.wr_scroll)   scroll_latch   <= s1_data;
      if (dec.wr_sprite)   sprite_store[wr_idx] <= s1_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= s1_valid;
    end
    if (fire) begin
      read_data         <= dec.read_data;
      sound_strobe      <= dec.sound_strobe;
      sound_register    <= dec.sound_register;
      sprite_read_value <= sprite_value_next;
    end
  end

  // latches change only when a word moves into the result register
  assign irq_enable          = irq_latch;
  assign flip_screen         = flip_latch;
  assign palette_bank        = palette_latch;
  assign color_table_bank    = color_latch;
  assign background_priority = priority_latch;
  assign character_bank      = char_latch;
  assign sprite_bank         = spr_bank_latch;
  assign scroll_y            = scroll_latch;

endmodule

[rtl/bioreg_checker.sv]
// port-level assertions for the board i/o register decoder, with bind
module bioreg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               rsp_valid,
  input logic                               rsp_stall,
  input logic [bioreg_pkg::DATA_W-1:0]      read_data,
  input logic                               sound_strobe,
  input logic [bioreg_pkg::SND_REG_W-1:0]   sound_register,
  input logic [bioreg_pkg::DATA_W-1:0]      irq_enable,
  input logic [bioreg_pkg::DATA_W-1:0]      scroll_y,
  input logic [bioreg_pkg::DATA_W-1:0]      palette_bank
);

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) &&
                               $stable(sound_strobe))
    else $error("stalled result word changed");

  // a sound strobe comes from a write, so no read data with it
  a_strobe_no_read: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && sound_strobe |-> read_data == '0)
    else $error("read data on a sound strobe word");

  // sound register index is zero without a strobe
  a_sreg_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !sound_strobe |-> sound_register == '0)
    else $error("sound register index without strobe");

  // latches only move when a new word enters the result register
  a_latch_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(irq_enable) && $stable(scroll_y) &&
                               $stable(palette_bank))
    else $error("latch changed while result stalled");

  // reset empties the pipe and clears latches
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && irq_enable == '0 && scroll_y == '0)
    else $error("state not cleared by reset");

endmodule

bind board_io_register_decode bioreg_checker u_bioreg_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .read_data      (read_data),
  .sound_strobe   (sound_strobe),
  .sound_register (sound_register),
  .irq_enable     (irq_enable),
  .scroll_y       (scroll_y),
  .palette_bank   (palette_bank)
);

[tb/sv/bioreg_tb_pkg.sv]
// word types and scoreboard for the board i/o register decoder testbench
`timescale 1ns / 1ps

package bioreg_tb_pkg;
  import bioreg_pkg::*;

  // one bus access word as accepted on the request channel
  typedef struct packed {
    logic                   req_type;
    logic [ADDR_W-1:0]      bus_address;
    logic [DATA_W-1:0]      write_data;
    logic [DATA_W-1:0]      player_one_port;
    logic [DATA_W-1:0]      player_two_port;
    logic [SPR_FIELD_W-1:0] sprite_read_index;
  } access_word_t;

  // one result word as seen on the result channel
  typedef struct packed {
    logic [DATA_W-1:0]    read_data;
    logic                 sound_strobe;
    logic [SND_REG_W-1:0] sound_register;
    logic [DATA_W-1:0]    irq_enable;
    logic                 flip_screen;
    logic [DATA_W-1:0]    palette_bank;
    logic [DATA_W-1:0]    color_table_bank;
    logic                 background_priority;
    logic                 character_bank;
    logic                 sprite_bank;
    logic [DATA_W-1:0]    scroll_y;
    logic [DATA_W-1:0]    sprite_read_value;
  } decode_word_t;

  class io_decode_scoreboard;
    // shadow of the dip banks, latches and sprite store
    logic [DATA_W-1:0] dip_a = DIP_A_RESET;
    logic [DATA_W-1:0] dip_b = DIP_B_RESET;
    logic [DATA_W-1:0] dip_c = DIP_C_RESET;
    logic [DATA_W-1:0] irq_q = '0;
    logic              flip_q = 1'b0;
    logic [DATA_W-1:0] palette_q = '0;
    logic [DATA_W-1:0] color_q = '0;
    logic              priority_q = 1'b0;
    logic              char_q = 1'b0;
    logic              spr_bank_q = 1'b0;
    logic [DATA_W-1:0] scroll_q = '0;
    logic [DATA_W-1:0] sprite_store [SPRITE_STORE_DEPTH];
    decode_word_t      decoded_q [$];
    int                mismatches = 0;

    function new();
      foreach (sprite_store[i]) sprite_store[i] = '0;
    endfunction

    // dip bank write seen on the configuration channel
    function void set_dip(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        CFG_DIP_A: dip_a = value;
        CFG_DIP_B: dip_b = value;
        CFG_DIP_C: dip_c = value;
        default: ;
      endcase
    endfunction

    // decode one accepted access and queue the word it should return
    function void note_access(access_word_t r);
      decode_word_t      e;
      logic [ADDR_W-1:0] ra;
      e = '0;
      if (r.req_type == REQ_WRITE) begin
        case (r.bus_address)
          ADDR_IRQ_EN:    irq_q = r.write_data;
          ADDR_FLIP:      flip_q = r.write_data[0];
          ADDR_PALETTE:   palette_q = r.write_data;
          ADDR_COLOR_TBL: color_q = r.write_data;
          ADDR_PRIORITY:  priority_q = r.write_data[0];
          ADDR_CHAR_BANK: char_q = r.write_data[0];
          ADDR_SPR_BANK:  spr_bank_q = r.write_data[0];
          ADDR_SCROLL:    scroll_q = r.write_data;
          default: begin
            if (r.bus_address[ADDR_W-1:5] == SOUND_WIN) begin
              e.sound_strobe = 1'b1;
              e.sound_register = r.bus_address[4:0];
            end else if (r.bus_address[ADDR_W-1:4] == SPRITE_WIN) begin
              sprite_store[r.bus_address[3:0]] = r.write_data;
            end
          end
        endcase
      end else begin
        // page 0x50xx ignores the low six address bits
        ra = r.bus_address;
        if (ra[ADDR_W-1:8] == IO_PAGE) ra = ra & MIRROR_MASK;
        case (ra)
          ADDR_RD_P1:   e.read_data = (r.player_one_port & P1_MASK) | (dip_a & DIPA_MASK);
          ADDR_RD_P2:   e.read_data = (r.player_two_port & P2_MASK) | (dip_b & DIPB_MASK);
          ADDR_RD_DIPC: e.read_data = dip_c;
          default:      e.read_data = '0;
        endcase
      end
      e.irq_enable = irq_q;
      e.flip_screen = flip_q;
      e.palette_bank = palette_q;
      e.color_table_bank = color_q;
      e.background_priority = priority_q;
      e.character_bank = char_q;
      e.sprite_bank = spr_bank_q;
      e.scroll_y = scroll_q;
      e.sprite_read_value = sprite_store[r.sprite_read_index];
      decoded_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    // compare one result word with the oldest queued one
    function void check_response(decode_word_t a);
      decode_word_t e;
      if (decoded_q.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatches++;
        return;
      end
      e = decoded_q.pop_front();
      compare_field("read_data", 16'(e.read_data), 16'(a.read_data));
      compare_field("sound_strobe", 16'(e.sound_strobe), 16'(a.sound_strobe));
      compare_field("sound_register", 16'(e.sound_register), 16'(a.sound_register));
      compare_field("irq_enable", 16'(e.irq_enable), 16'(a.irq_enable));
      compare_field("flip_screen", 16'(e.flip_screen), 16'(a.flip_screen));
      compare_field("palette_bank", 16'(e.palette_bank), 16'(a.palette_bank));
      compare_field("color_table_bank", 16'(e.color_table_bank),
                    16'(a.color_table_bank));
      compare_field("background_priority", 16'(e.background_priority),
                    16'(a.background_priority));
      compare_field("character_bank", 16'(e.character_bank), 16'(a.character_bank));
      compare_field("sprite_bank", 16'(e.sprite_bank), 16'(a.sprite_bank));
      compare_field("scroll_y", 16'(e.scroll_y), 16'(a.scroll_y));
      compare_field("sprite_read_value", 16'(e.sprite_read_value),
                    16'(a.sprite_read_value));
    endfunction

    function int outstanding();
      return decoded_q.size();
    endfunction
  endclass

endpackage

[tb/sv/tb_top.sv]
// top of the board i/o register decoder testbench: clock, drivers, monitor
`timescale 1ns / 1ps

module tb_top;
  import bioreg_pkg::*;
  import bioreg_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS = 460;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  logic                   req_type = REQ_READ;
  logic [ADDR_W-1:0]      bus_address = '0;
  logic [DATA_W-1:0]      write_data = '0;
  logic [DATA_W-1:0]      player_one_port = '0;
  logic [DATA_W-1:0]      player_two_port = '0;
  logic [SPR_FIELD_W-1:0] sprite_read_index = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_DIP_A;
  logic [DATA_W-1:0]      cfg_data = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  logic [DATA_W-1:0]      read_data;
  logic                   sound_strobe;
  logic [SND_REG_W-1:0]   sound_register;
  logic [DATA_W-1:0]      irq_enable;
  logic                   flip_screen;
  logic [DATA_W-1:0]      palette_bank;
  logic [DATA_W-1:0]      color_table_bank;
  logic                   background_priority;
  logic                   character_bank;
  logic                   sprite_bank;
  logic [DATA_W-1:0]      scroll_y;
  logic [DATA_W-1:0]      sprite_read_value;

  io_decode_scoreboard sb = new();
  bit                  no_idle = 1'b0;
  decode_word_t        seen;
  int                  quiet_cycles = 0;

  board_io_register_decode u_top (
    .clk                 (clk),
    .rst                 (rst),
    .req_valid           (req_valid),
    .req_stall           (req_stall),
    .req_type            (req_type),
    .bus_address         (bus_address),
    .write_data          (write_data),
    .player_one_port     (player_one_port),
    .player_two_port     (player_two_port),
    .sprite_read_index   (sprite_read_index),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .rsp_valid           (rsp_valid),
    .rsp_stall           (rsp_stall),
    .read_data           (read_data),
    .sound_strobe        (sound_strobe),
    .sound_register      (sound_register),
    .irq_enable          (irq_enable),
    .flip_screen         (flip_screen),
    .palette_bank        (palette_bank),
    .color_table_bank    (color_table_bank),
    .background_priority (background_priority),
    .character_bank      (character_bank),
    .sprite_bank         (sprite_bank),
    .scroll_y            (scroll_y),
    .sprite_read_value   (sprite_read_value)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // access with random ports and store index
  function automatic access_word_t access(logic kind, logic [ADDR_W-1:0] addr,
                                          logic [DATA_W-1:0] data);
    access_word_t r;
    r.req_type = kind;
    r.bus_address = addr;
    r.write_data = data;
    r.player_one_port = 8'($urandom);
    r.player_two_port = 8'($urandom);
    r.sprite_read_index = 4'($urandom);
    return r;
  endfunction

  // random access, mostly aimed at the i/o page and the latch addresses
  function automatic access_word_t random_access();
    access_word_t r;
    int           pick;
    r = access(1'($urandom), '0, 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.bus_address = {IO_PAGE, 8'($urandom)};
    end else if (pick < 65) begin
      case ($urandom_range(0, 7))
        0: r.bus_address = ADDR_IRQ_EN;
        1: r.bus_address = ADDR_FLIP;
        2: r.bus_address = ADDR_PALETTE;
        3: r.bus_address = ADDR_COLOR_TBL;
        4: r.bus_address = ADDR_PRIORITY;
        5: r.bus_address = ADDR_CHAR_BANK;
        6: r.bus_address = ADDR_SPR_BANK;
        default: r.bus_address = ADDR_SCROLL;
      endcase
    end else if (pick < 80) begin
      r.bus_address = {SPRITE_WIN, 4'($urandom)};
    end else begin
      r.bus_address = 16'($urandom);
    end
    return r;
  endfunction

  // drive one request word, with an occasional gap before it
  task automatic issue_access(input access_word_t r);
    if (!no_idle && $urandom_range(0, 99) < 10) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= r.req_type;
    bus_address <= r.bus_address;
    write_data <= r.write_data;
    player_one_port <= r.player_one_port;
    player_two_port <= r.player_two_port;
    sprite_read_index <= r.sprite_read_index;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_access(r);
  endtask

  // one configuration word, valid left high for the caller
  task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_dip(idx, value);
  endtask

  // all three dip banks plus the unused index
  task automatic load_dip_banks(input logic [DATA_W-1:0] a, b, c);
    cfg_beat(CFG_DIP_A, a);
    cfg_beat(CFG_DIP_B, b);
    cfg_beat(CFG_DIP_C, c);
    cfg_beat(CFG_SPARE, 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stop requesting and let every outstanding word come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int count, input bit with_quiet);
    for (int n = 0; n < count; n++) begin
      no_idle = with_quiet && n >= 100 && n < 400;
      issue_access(random_access());
    end
    no_idle = 1'b0;
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    rsp_stall <= !rst && !no_idle && ($urandom_range(0, 99) < 10);
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      seen.read_data = read_data;
      seen.sound_strobe = sound_strobe;
      seen.sound_register = sound_register;
      seen.irq_enable = irq_enable;
      seen.flip_screen = flip_screen;
      seen.palette_bank = palette_bank;
      seen.color_table_bank = color_table_bank;
      seen.background_priority = background_priority;
      seen.character_bank = character_bank;
      seen.sprite_bank = sprite_bank;
      seen.scroll_y = scroll_y;
      seen.sprite_read_value = sprite_read_value;
      sb.check_response(seen);
    end
  end

  // watchdog on cycles with no word moving on any channel
  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // stimulus
  initial begin
    access_word_t d;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reads at the reset dip values, mirrors and unmapped pages
    d = access(REQ_READ, ADDR_RD_P1, 8'h00);
    d.player_one_port = 8'hff;
    issue_access(d);
    d = access(REQ_READ, ADDR_RD_P2, 8'h00);
    d.player_two_port = 8'hff;
    issue_access(d);
    issue_access(access(REQ_READ, ADDR_RD_DIPC, 8'h00));
    issue_access(access(REQ_READ, 16'h50c0, 8'h00));
    issue_access(access(REQ_READ, 16'h50ff, 8'h00));
    issue_access(access(REQ_READ, 16'h507f, 8'h00));
    issue_access(access(REQ_READ, 16'h0000, 8'h00));
    issue_access(access(REQ_READ, 16'hffff, 8'hff));

    // every latch, with bit 0 only taken on the single-bit ones
    issue_access(access(REQ_WRITE, ADDR_IRQ_EN, 8'hff));
    issue_access(access(REQ_WRITE, ADDR_FLIP, 8'hff));
    issue_access(access(REQ_WRITE, ADDR_PALETTE, 8'ha5));
    issue_access(access(REQ_WRITE, ADDR_COLOR_TBL, 8'h5a));
    issue_access(access(REQ_WRITE, ADDR_PRIORITY, 8'hfe));
    issue_access(access(REQ_WRITE, ADDR_CHAR_BANK, 8'h01));
    issue_access(access(REQ_WRITE, ADDR_SPR_BANK, 8'h01));
    issue_access(access(REQ_WRITE, ADDR_SCROLL, 8'h80));

    // sound window edges
    issue_access(access(REQ_WRITE, 16'h5040, 8'h33));
    issue_access(access(REQ_WRITE, 16'h505f, 8'hcc));

    // sprite store edges, read back in the same word
    d = access(REQ_WRITE, 16'h5060, 8'h11);
    d.sprite_read_index = 4'h0;
    issue_access(d);
    d = access(REQ_WRITE, 16'h506f, 8'hee);
    d.sprite_read_index = 4'hf;
    issue_access(d);

    // unmapped writes leave everything alone
    issue_access(access(REQ_WRITE, 16'h5001, 8'hff));
    issue_access(access(REQ_WRITE, 16'h50c0, 8'hff));
    issue_access(access(REQ_WRITE, 16'h0000, 8'hff));

    // read ignores write data
    d = access(REQ_READ, ADDR_RD_P1, 8'hff);
    d.sprite_read_index = 4'hf;
    issue_access(d);
    wait_drained();

    // random phases across dip settings
    load_dip_banks(8'h00, 8'h00, 8'h00);
    random_phase(PHASE_ITEMS, 1'b1);
    wait_drained();
    load_dip_banks(8'hff, 8'hff, 8'hff);
    random_phase(PHASE_ITEMS, 1'b0);
    wait_drained();
    load_dip_banks(8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(PHASE_ITEMS, 1'b0);
    wait_drained();
    load_dip_banks(8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(PHASE_ITEMS, 1'b0);
    wait_drained();

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      if (sb.outstanding() != 0) $error("%0d result words never arrived", sb.outstanding());
      $display("FAIL");
    end
    $finish;
  end

endmodule
